// ===== sv/ticon_pkg.sv =====
// Shared types and constants for the tiled 4bpp icon pixel decoder.
// No dependencies; every other file refers to this package by scoped names.
package ticon_pkg;

    localparam int PaletteEntries = 16;
    localparam int IndexWidth     = 4;
    localparam int ColourWidth    = 15;
    localparam int ChanWidth      = 5;
    localparam int PosWidth       = 5;

    localparam logic ACTION_PALETTE = 1'b0;
    localparam logic ACTION_PIXEL   = 1'b1;

    localparam logic [IndexWidth-1:0] INDEX_TRANSPARENT = '0;
    localparam logic [7:0]            CHAN_WHITE        = 8'hFF;

    // One decoded command travelling from the front to the back.
    typedef struct packed {
        logic                   action;
        logic [IndexWidth-1:0]  entry_index;
        logic [ColourWidth-1:0] colour;
        logic [PosWidth-1:0]    base_x;
        logic [PosWidth-1:0]    pos_y;
        logic [IndexWidth-1:0]  nib_lo;
        logic [IndexWidth-1:0]  nib_hi;
    } cmd_t;

    // One finished pixel.
    typedef struct packed {
        logic [PosWidth-1:0] pos_x;
        logic [PosWidth-1:0] pos_y;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic                drawn;
        logic                last_of_pair;
    } pixel_t;

    // Widen a 5-bit channel to 8 bits by replicating its top bits.
    function automatic logic [7:0] widen_channel(input logic [ChanWidth-1:0] v);
        widen_channel = {v, v[ChanWidth-1:ChanWidth-3]};
    endfunction

endpackage

// ===== sv/ticon_front.sv =====
// Front stage of the icon decoder: accepts input transactions, classifies
// them and works out tile-derived coordinates. Depends on ticon_pkg.
module ticon_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 action,
    input  logic [3:0]           entry_index,
    input  logic [15:0]          color_word,
    input  logic [8:0]           byte_position,
    input  logic [7:0]           pixel_byte,
    output logic                 cmd_valid,
    output ticon_pkg::cmd_t      cmd,
    input  logic                 cmd_full
);

    logic            valid_reg;
    logic            valid_next;
    ticon_pkg::cmd_t cmd_reg;
    ticon_pkg::cmd_t cmd_next;
    logic            accept;
    logic [3:0]      tile;
    logic [4:0]      tile_byte;

    assign full   = valid_reg && cmd_full;
    assign accept = push && !full;

    assign tile      = byte_position[8:5];
    assign tile_byte = byte_position[4:0];

    always_comb
    begin
        cmd_next.action      = action;
        cmd_next.entry_index = entry_index;
        cmd_next.colour      = color_word[14:0];
        // Four tiles across: low tile bits pick the column, high bits the row.
        cmd_next.base_x      = {tile[1:0], tile_byte[1:0], 1'b0};
        cmd_next.pos_y       = {tile[3:2], tile_byte[4:2]};
        cmd_next.nib_lo      = pixel_byte[3:0];
        cmd_next.nib_hi      = pixel_byte[7:4];
    end

    assign valid_next = accept || (valid_reg && cmd_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== sv/ticon_queue.sv =====
// Short command queue between the front and back of the icon decoder.
// Depends on ticon_pkg for the command type.
module ticon_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  ticon_pkg::cmd_t wr_data,
    output logic            q_full,
    input  logic            rd_en,
    output logic            q_valid,
    output ticon_pkg::cmd_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ticon_pkg::cmd_t store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/ticon_back.sv =====
// Back stage of the icon decoder: holds the palette, carries out palette
// writes and turns each bitmap byte into two pixels. Depends on ticon_pkg.
module ticon_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  ticon_pkg::cmd_t  q_head,
    output logic             q_pop,
    output logic             out_valid,
    output ticon_pkg::pixel_t out_pixel,
    input  logic             out_taken
);

    logic [ticon_pkg::ColourWidth-1:0] palette [ticon_pkg::PaletteEntries];

    logic              phase_reg;
    logic              phase_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    ticon_pkg::pixel_t pixel_reg;
    ticon_pkg::pixel_t pixel_next;
    logic              slot_free;
    logic              emit;
    logic              pal_write;
    logic [ticon_pkg::IndexWidth-1:0]  idx;
    logic [ticon_pkg::ColourWidth-1:0] colour;

    // The output register can take a pixel when empty or being drained now.
    assign slot_free = !out_valid_reg || out_taken;

    always_comb
    begin
        emit      = 1'b0;
        pal_write = 1'b0;
        q_pop     = 1'b0;
        unique case (q_head.action)
            ticon_pkg::ACTION_PALETTE:
            begin
                pal_write = q_valid;
                q_pop     = q_valid;
            end
            ticon_pkg::ACTION_PIXEL:
            begin
                emit  = q_valid && slot_free;
                q_pop = emit && phase_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign idx    = phase_reg ? q_head.nib_hi : q_head.nib_lo;
    assign colour = palette[idx];

    always_comb
    begin
        pixel_next.pos_x        = {q_head.base_x[ticon_pkg::PosWidth-1:1], phase_reg};
        pixel_next.pos_y        = q_head.pos_y;
        pixel_next.last_of_pair = phase_reg;
        if (idx == ticon_pkg::INDEX_TRANSPARENT)
        begin
            pixel_next.red   = ticon_pkg::CHAN_WHITE;
            pixel_next.green = ticon_pkg::CHAN_WHITE;
            pixel_next.blue  = ticon_pkg::CHAN_WHITE;
            pixel_next.drawn = 1'b0;
        end
        else
        begin
            pixel_next.red   = ticon_pkg::widen_channel(colour[4:0]);
            pixel_next.green = ticon_pkg::widen_channel(colour[9:5]);
            pixel_next.blue  = ticon_pkg::widen_channel(colour[14:10]);
            pixel_next.drawn = 1'b1;
        end
    end

    assign phase_next     = emit ? !phase_reg : phase_reg;
    assign out_valid_next = emit || (out_valid_reg && !out_taken);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_reg <= pixel_next;
        end
        if (pal_write)
        begin
            palette[q_head.entry_index] <= q_head.colour;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = pixel_reg;

endmodule

// ===== sv/tiled_4bpp_icon_pixel_decoder_unit.sv =====
// Tiled 4bpp icon pixel decoder. A palette-write transaction is carried out
// in the back stage and gives no result; a bitmap-byte transaction gives two
// pixels, one after the other, through the result register, which takes one
// pixel per cycle while it is empty or being popped. A front register and a
// command queue of QUEUE_DEPTH entries decouple input from output, so input
// keeps flowing while a result waits, until the queue and front register fill;
// pixels pass through the front register, the queue and the result register.
// Palette entries must be written before use.
module tiled_4bpp_icon_pixel_decoder_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [3:0]  entry_index,
    input  logic [15:0] color_word,
    input  logic [8:0]  byte_position,
    input  logic [7:0]  pixel_byte,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  pos_x,
    output logic [4:0]  pos_y,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        drawn,
    output logic        last_of_pair
);

    logic              f_valid;
    ticon_pkg::cmd_t   f_cmd;
    logic              q_full;
    logic              q_valid;
    ticon_pkg::cmd_t   q_head;
    logic              q_pop;
    logic              out_valid;
    ticon_pkg::pixel_t out_pixel;

    ticon_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .entry_index   (entry_index),
        .color_word    (color_word),
        .byte_position (byte_position),
        .pixel_byte    (pixel_byte),
        .cmd_valid     (f_valid),
        .cmd           (f_cmd),
        .cmd_full      (q_full)
    );

    ticon_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_data (f_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_valid (q_valid),
        .rd_data (q_head)
    );

    ticon_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_pixel (out_pixel),
        .out_taken (pop)
    );

    assign empty        = !out_valid;
    assign pos_x        = out_pixel.pos_x;
    assign pos_y        = out_pixel.pos_y;
    assign red          = out_pixel.red;
    assign green        = out_pixel.green;
    assign blue         = out_pixel.blue;
    assign drawn        = out_pixel.drawn;
    assign last_of_pair = out_pixel.last_of_pair;

endmodule

// ===== test/tiled_4bpp_icon_pixel_decoder_unit_tb.sv =====
// Self-checking testbench for the tiled 4bpp icon pixel decoder: queue-style
// driver and monitors with a palette-tracking pixel predictor.
// Depends on ticon_pkg and tiled_4bpp_icon_pixel_decoder_unit.
module tiled_4bpp_icon_pixel_decoder_unit_tb;

    localparam int RANDOM_ITEMS = 1425;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic        action;
        logic [3:0]  index;
        logic [15:0] colour;
        logic [8:0]  position;
        logic [7:0]  nibbles;
    } icon_txn_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        push          = 1'b0;
    logic        action        = ticon_pkg::ACTION_PALETTE;
    logic [3:0]  entry_index   = '0;
    logic [15:0] color_word    = '0;
    logic [8:0]  byte_position = '0;
    logic [7:0]  pixel_byte    = '0;
    logic        pop           = 1'b0;
    logic        full;
    logic        empty;
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        drawn;
    logic        last_of_pair;

    icon_txn_t              pending_txns[$];
    ticon_pkg::pixel_t      expected_pixels[$];
    logic [14:0]            palette_copy[16];
    bit [15:0]              entry_written;
    icon_txn_t              current_txn;
    ticon_pkg::pixel_t      oldest_pixel;
    bit                     offering;
    bit                     in_taken;
    bit                     out_taken;
    bit                     send_burst;
    bit                     recv_burst;
    bit                     hold_started;
    int                     send_gap;
    int                     recv_wait;
    int                     hold_left;
    int                     results_seen;
    int                     mismatches;

    tiled_4bpp_icon_pixel_decoder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .entry_index   (entry_index),
        .color_word    (color_word),
        .byte_position (byte_position),
        .pixel_byte    (pixel_byte),
        .empty         (empty),
        .pop           (pop),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .drawn         (drawn),
        .last_of_pair  (last_of_pair)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] expand_channel(input logic [4:0] v);
        return {v, 3'b000} + {5'b00000, v[4:2]};
    endfunction

    function automatic ticon_pkg::pixel_t shade_pixel(input logic [4:0] x,
                                                      input logic [4:0] y,
                                                      input logic [3:0] idx,
                                                      input logic second);
        ticon_pkg::pixel_t p;
        logic [14:0]       c;
        c              = palette_copy[idx];
        p.pos_x        = x;
        p.pos_y        = y;
        p.last_of_pair = second;
        if (idx == ticon_pkg::INDEX_TRANSPARENT)
        begin
            p.red   = 8'd255;
            p.green = 8'd255;
            p.blue  = 8'd255;
            p.drawn = 1'b0;
        end
        else
        begin
            p.red   = expand_channel(c[4:0]);
            p.green = expand_channel(c[9:5]);
            p.blue  = expand_channel(c[14:10]);
            p.drawn = 1'b1;
        end
        return p;
    endfunction

    // Palette writes update the local copy; bitmap bytes queue two pixels.
    function automatic void decode_transaction(input logic act, input logic [3:0] idx,
                                               input logic [15:0] colour,
                                               input logic [8:0] position,
                                               input logic [7:0] nibbles);
        logic [3:0] tile;
        logic [4:0] tile_byte;
        logic [4:0] x;
        logic [4:0] y;
        if (act == ticon_pkg::ACTION_PALETTE)
        begin
            palette_copy[idx] = colour[14:0];
            return;
        end
        tile      = position[8:5];
        tile_byte = position[4:0];
        x         = {tile[1:0], 3'b000} + {2'b00, tile_byte[1:0], 1'b0};
        y         = {tile[3:2], 3'b000} + {2'b00, tile_byte[4:2]};
        expected_pixels.push_back(shade_pixel(x, y, nibbles[3:0], 1'b0));
        expected_pixels.push_back(shade_pixel(x + 5'd1, y, nibbles[7:4], 1'b1));
    endfunction

    function automatic void queue_palette_write(input logic [3:0] idx,
                                                input logic [15:0] colour);
        icon_txn_t t;
        t.action   = ticon_pkg::ACTION_PALETTE;
        t.index    = idx;
        t.colour   = colour;
        t.position = 9'($urandom);
        t.nibbles  = 8'($urandom);
        entry_written[idx] = 1'b1;
        pending_txns.push_back(t);
    endfunction

    function automatic void queue_bitmap_byte(input logic [8:0] position,
                                              input logic [7:0] nibbles);
        icon_txn_t t;
        t.action   = ticon_pkg::ACTION_PIXEL;
        t.index    = 4'($urandom);
        t.colour   = 16'($urandom);
        t.position = position;
        t.nibbles  = nibbles;
        pending_txns.push_back(t);
    endfunction

    // Only transparent or already-written entries may be referenced.
    function automatic logic [3:0] pick_index();
        logic [3:0] n;
        if ($urandom_range(0, 7) == 0 || entry_written[15:1] == '0)
            return ticon_pkg::INDEX_TRANSPARENT;
        do
            n = 4'($urandom_range(1, 15));
        while (!entry_written[n]);
        return n;
    endfunction

    // Every so often switch between a burst with no idling and random gaps.
    function automatic int draw_idle(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 14));
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Sender: offers one transaction at a time and holds it until accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (offering && in_taken)
            begin
                offering = 1'b0;
                in_taken = 1'b0;
                send_gap = draw_idle(send_burst);
                if (hold_left > 0)
                    send_gap = 0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_txns.size() > 0)
                begin
                    current_txn   = pending_txns.pop_front();
                    action        <= current_txn.action;
                    entry_index   <= current_txn.index;
                    color_word    <= current_txn.colour;
                    byte_position <= current_txn.position;
                    pixel_byte    <= current_txn.nibbles;
                    offering      = 1'b1;
                end
            end
            push <= offering;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            in_taken = 1'b1;
            decode_transaction(action, entry_index, color_word, byte_position, pixel_byte);
        end
    end

    // Receiver: random waits per result, plus one long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                recv_wait = draw_idle(recv_burst);
            end
            if (hold_left > 0)
                pop <= 1'b0;
            else if (recv_wait > 0)
            begin
                recv_wait--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_started && results_seen >= HOLD_AFTER)
            begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            else if (hold_left > 0)
                hold_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            out_taken = 1'b1;
            results_seen++;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d",
                         $time, pos_x, pos_y);
            end
            else
            begin
                oldest_pixel = expected_pixels.pop_front();
                compare_field("pos_x", oldest_pixel.pos_x, pos_x);
                compare_field("pos_y", oldest_pixel.pos_y, pos_y);
                compare_field("red", oldest_pixel.red, red);
                compare_field("green", oldest_pixel.green, green);
                compare_field("blue", oldest_pixel.blue, blue);
                compare_field("drawn", oldest_pixel.drawn, drawn);
                compare_field("last_of_pair", oldest_pixel.last_of_pair, last_of_pair);
            end
        end
    end

    initial
    begin
        // Transparent pixels need no palette, so they may come first.
        queue_bitmap_byte(9'd0, 8'h00);
        queue_bitmap_byte(9'd511, 8'h00);
        queue_palette_write(4'd1, 16'h0000);
        queue_palette_write(4'd15, 16'hFFFF);
        queue_palette_write(4'd0, 16'h7FFF);
        queue_palette_write(4'd2, 16'h001F);
        queue_palette_write(4'd3, 16'h03E0);
        queue_palette_write(4'd4, 16'h7C00);
        queue_palette_write(4'd5, 16'h8000);
        queue_bitmap_byte(9'd0, 8'h10);
        queue_bitmap_byte(9'd511, 8'hF1);
        queue_bitmap_byte(9'd31, 8'h0F);
        queue_bitmap_byte(9'd32, 8'h32);
        queue_bitmap_byte(9'd480, 8'h54);
        queue_bitmap_byte(9'd255, 8'hF0);
        for (int i = 6; i < 15; i++)
            queue_palette_write(4'(i), 16'($urandom));
        queue_palette_write(4'd15, 16'h0000);
        queue_bitmap_byte(9'd127, 8'hFF);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_palette_write(4'($urandom), 16'($urandom));
            else
                queue_bitmap_byte(9'($urandom), {pick_index(), pick_index()});
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_txns.size() > 0 || offering || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
